// File: sv/tpab_pkg.sv
// ----------------------------------------------------------------------------
// tpab_pkg
// shared widths, codes and types of the two-pool allocation budget tracker
// ----------------------------------------------------------------------------
package tpab_pkg;

    localparam int BYTE_WIDTH    = 48;
    localparam int COUNT_WIDTH   = 32;
    localparam int CFG_IDX_WIDTH = 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;

    typedef logic [BYTE_WIDTH-1:0]  t_bytes;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [1:0] {
        KIND_RESERVE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REDUCE  = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_REFUSED    = 2'd1,
        STATUS_REDUCE_BIG = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_TOTAL_LIMIT   = 1'b0,
        CFG_COMPACT_LIMIT = 1'b1
    } t_cfg_index;

    // classified operation handed from front to back
    typedef struct packed {
        t_kind  kind;
        logic   compact;
        logic   reduce_big;
        t_bytes amount;
        t_bytes reported;
    } t_op;

endpackage

// File: sv/tpab_req_if.sv
// ----------------------------------------------------------------------------
// tpab_req_if
// request channel: one budget operation per word
// ----------------------------------------------------------------------------
interface tpab_req_if
    import tpab_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [BYTE_WIDTH-1:0] size;
    logic                  category;
    logic [BYTE_WIDTH-1:0] held_size;
    logic [BYTE_WIDTH-1:0] reported_available;

    modport source (
        output valid, kind, size, category, held_size, reported_available,
        input  ready
    );

    modport sink (
        input  valid, kind, size, category, held_size, reported_available,
        output ready
    );
endinterface

// File: sv/tpab_rsp_if.sv
// ----------------------------------------------------------------------------
// tpab_rsp_if
// response channel: status and counter snapshot per word
// ----------------------------------------------------------------------------
interface tpab_rsp_if
    import tpab_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [BYTE_WIDTH-1:0]  available;
    logic [BYTE_WIDTH-1:0]  allocated_bytes;
    logic [BYTE_WIDTH-1:0]  compact_bytes;
    logic [BYTE_WIDTH-1:0]  peak_bytes;
    logic [COUNT_WIDTH-1:0] rejected_count;
    logic [BYTE_WIDTH-1:0]  refused_size;
    logic [BYTE_WIDTH-1:0]  refused_free;

    modport source (
        output valid, status, available, allocated_bytes, compact_bytes, peak_bytes,
               rejected_count, refused_size, refused_free,
        input  ready
    );

    modport sink (
        input  valid, status, available, allocated_bytes, compact_bytes, peak_bytes,
               rejected_count, refused_size, refused_free,
        output ready
    );
endinterface

// File: sv/tpab_front.sv
// ----------------------------------------------------------------------------
// tpab_front
// accepts requests, works out the reduce delta and registers the operation
// ----------------------------------------------------------------------------
module tpab_front
    import tpab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpab_req_if.sink   i_req,
    output logic       o_op_valid,
    input  logic       i_op_ready,
    output t_op        o_op
);

    logic r_valid;
    t_op  r_op;
    t_op  n_op;

    assign i_req.ready = !r_valid || i_op_ready;

    always_comb begin
        n_op.kind       = t_kind'(i_req.kind);
        n_op.compact    = i_req.category;
        n_op.reduce_big = 1'b0;
        n_op.amount     = i_req.size;
        n_op.reported   = i_req.reported_available;
        if (n_op.kind == KIND_REDUCE) begin
            n_op.reduce_big = i_req.size > i_req.held_size;
            n_op.amount     = i_req.held_size - i_req.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

// File: sv/tpab_queue.sv
// ----------------------------------------------------------------------------
// tpab_queue
// two-entry fifo between classification and execution
// ----------------------------------------------------------------------------
module tpab_queue
    import tpab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_op  i_wr_op,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_op  o_rd_op
);

    t_op                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   wr_en;
    logic                   rd_en;

    assign o_wr_ready = r_count != QUEUE_PTR_W'(0) + (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;
    assign o_rd_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_op;
        end
    end

endmodule

// File: sv/tpab_back.sv
// ----------------------------------------------------------------------------
// tpab_back
// holds limits and counters, executes one operation per cycle into the
// response register while the response is taken
// ----------------------------------------------------------------------------
module tpab_back
    import tpab_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [BYTE_WIDTH-1:0]    i_cfg_data,
    input  logic                     i_op_valid,
    output logic                     o_op_ready,
    input  t_op                      i_op,
    tpab_rsp_if.source               o_rsp
);

    t_bytes  r_total_limit;
    t_bytes  r_compact_limit;
    t_bytes  r_used_total;
    t_bytes  r_used_compact;
    t_bytes  r_peak;
    t_count  r_refusals;
    t_bytes  r_refused_size;
    t_bytes  r_refused_free;
    logic    r_out_valid;
    t_status r_status;
    t_bytes  r_available;

    t_bytes  n_used_total;
    t_bytes  n_used_compact;
    t_bytes  n_peak;
    t_count  n_refusals;
    t_bytes  n_refused_size;
    t_bytes  n_refused_free;
    t_status n_status;
    t_bytes  n_available;

    t_bytes  free_total;
    t_bytes  free_compact;
    t_bytes  avail;
    t_bytes  sum_total;
    logic    step;

    assign o_op_ready = !r_out_valid || o_rsp.ready;
    assign step       = i_op_valid && o_op_ready;

    assign free_total   = (r_total_limit > r_used_total) ?
                          r_total_limit - r_used_total : '0;
    assign free_compact = (r_compact_limit > r_used_compact) ?
                          r_compact_limit - r_used_compact : '0;
    assign avail        = (i_op.compact && free_compact < free_total) ?
                          free_compact : free_total;
    assign sum_total    = r_used_total + i_op.amount;

    always_comb begin
        n_used_total   = r_used_total;
        n_used_compact = r_used_compact;
        n_peak         = r_peak;
        n_refusals     = r_refusals;
        n_refused_size = r_refused_size;
        n_refused_free = r_refused_free;
        n_status       = STATUS_OK;
        n_available    = '0;
        unique case (i_op.kind)
            KIND_RESERVE: begin
                n_available = avail;
                if (i_op.amount > avail) begin
                    n_status       = STATUS_REFUSED;
                    n_refusals     = (r_refusals == '1) ? r_refusals : r_refusals + 1'b1;
                    n_refused_size = i_op.amount;
                    n_refused_free = avail;
                end else begin
                    n_used_total = sum_total;
                    if (i_op.compact) begin
                        n_used_compact = r_used_compact + i_op.amount;
                    end
                    if (sum_total > r_peak) begin
                        n_peak = sum_total;
                    end
                end
            end
            KIND_RELEASE, KIND_REDUCE: begin
                if (i_op.reduce_big) begin
                    n_status = STATUS_REDUCE_BIG;
                end else begin
                    n_used_total = (r_used_total > i_op.amount) ?
                                   r_used_total - i_op.amount : '0;
                    if (i_op.compact) begin
                        n_used_compact = (r_used_compact > i_op.amount) ?
                                         r_used_compact - i_op.amount : '0;
                    end
                end
            end
            KIND_REJECT: begin
                n_refusals     = (r_refusals == '1) ? r_refusals : r_refusals + 1'b1;
                n_refused_size = i_op.amount;
                n_refused_free = i_op.reported;
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_limit   <= '0;
            r_compact_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TOTAL_LIMIT:   r_total_limit   <= i_cfg_data;
                CFG_COMPACT_LIMIT: r_compact_limit <= i_cfg_data;
                default:           r_total_limit   <= r_total_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_total   <= '0;
            r_used_compact <= '0;
            r_peak         <= '0;
            r_refusals     <= '0;
            r_refused_size <= '0;
            r_refused_free <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_op_ready) begin
                r_out_valid <= i_op_valid;
            end
            if (step) begin
                r_used_total   <= n_used_total;
                r_used_compact <= n_used_compact;
                r_peak         <= n_peak;
                r_refusals     <= n_refusals;
                r_refused_size <= n_refused_size;
                r_refused_free <= n_refused_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status    <= n_status;
            r_available <= n_available;
        end
    end

    // snapshot registers double as the response payload
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.available       = r_available;
    assign o_rsp.allocated_bytes = r_used_total;
    assign o_rsp.compact_bytes   = r_used_compact;
    assign o_rsp.peak_bytes      = r_peak;
    assign o_rsp.rejected_count  = r_refusals;
    assign o_rsp.refused_size    = r_refused_size;
    assign o_rsp.refused_free    = r_refused_free;

endmodule

// File: sv/two_pool_allocation_budget.sv
// ----------------------------------------------------------------------------
// two_pool_allocation_budget
// byte-budget tracker with a total pool and a compact-index sub-pool
// ----------------------------------------------------------------------------
// The block takes one request word per cycle, unless the response side stalls,
// and returns one response word per request, in order. A request is registered
// in the front stage, written into a two-entry queue and executed in the back
// stage into its response register. The sustained rate of one word per cycle
// is set by the back stage, which updates all counters for one request at once.
// The user must write limits through the configuration port while no request
// is in flight; the block does not enforce this.
module two_pool_allocation_budget
    import tpab_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [BYTE_WIDTH-1:0]    i_cfg_data,
    tpab_req_if.sink                 i_req,
    tpab_rsp_if.source               o_rsp
);

    logic front_valid;
    logic front_ready;
    t_op  front_op;
    logic queue_valid;
    logic queue_ready;
    t_op  queue_op;

    tpab_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_op_valid (front_valid),
        .i_op_ready (front_ready),
        .o_op       (front_op)
    );

    tpab_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_op    (front_op),
        .o_rd_valid (queue_valid),
        .i_rd_ready (queue_ready),
        .o_rd_op    (queue_op)
    );

    tpab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op_valid  (queue_valid),
        .o_op_ready  (queue_ready),
        .i_op        (queue_op),
        .o_rsp       (o_rsp)
    );

endmodule

// File: sv/tpab_checker.sv
// ----------------------------------------------------------------------------
// tpab_checker
// port-level checks of the budget tracker, bound to the top level
// ----------------------------------------------------------------------------
module tpab_checker
    import tpab_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   i_ready,
    input logic [1:0]             i_status,
    input logic [BYTE_WIDTH-1:0]  i_available,
    input logic [BYTE_WIDTH-1:0]  i_allocated,
    input logic [BYTE_WIDTH-1:0]  i_peak,
    input logic [BYTE_WIDTH-1:0]  i_refused_free,
    input logic [COUNT_WIDTH-1:0] i_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("response valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_allocated)
                               && $stable(i_count))
        else $error("stalled response changed");

    a_refusal_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == STATUS_REFUSED |-> i_refused_free == i_available)
        else $error("refusal did not record free space");

    a_reduce_no_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == STATUS_REDUCE_BIG |-> i_available == '0)
        else $error("available nonzero on reduce error");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_allocated <= i_peak)
        else $error("bytes in use above peak");

endmodule

bind two_pool_allocation_budget tpab_checker u_tpab_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_available    (o_rsp.available),
    .i_allocated    (o_rsp.allocated_bytes),
    .i_peak         (o_rsp.peak_bytes),
    .i_refused_free (o_rsp.refused_free),
    .i_count        (o_rsp.rejected_count)
);
